FILE: rtl/clps_pkg.sv
package clps_pkg;

  localparam int unsigned NUM_LINES  = 6;
  localparam int unsigned NUM_ROWS   = 5;
  localparam int unsigned NUM_COLS   = 5;
  localparam int unsigned NUM_PIXELS = NUM_ROWS * NUM_COLS;

  localparam int unsigned FRAME_W = NUM_PIXELS;
  localparam int unsigned DWELL_W = 16;
  localparam int unsigned GROUP_W = 3;

  localparam logic [GROUP_W-1:0] LAST_GROUP  = 3'd5;
  localparam logic [DWELL_W-1:0] DWELL_RESET = 16'd1;

  // Request opcodes.
  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  // Pixel group of each pixel, indexed by 5*row+col.
  localparam logic [GROUP_W-1:0] PIXEL_GROUP [NUM_PIXELS] = '{
    3'd0, 3'd0, 3'd0, 3'd0, 3'd0,
    3'd2, 3'd1, 3'd1, 3'd1, 3'd1,
    3'd3, 3'd3, 3'd2, 3'd2, 3'd2,
    3'd4, 3'd4, 3'd4, 3'd3, 3'd3,
    3'd5, 3'd5, 3'd5, 3'd5, 3'd4
  };

  typedef struct packed {
    logic [NUM_LINES-1:0] enable;
    logic [NUM_LINES-1:0] high;
  } lines_t;

  // Line drive for one group: the group's anode line is high when any pixel in
  // the group is lit, and the cathode line of every lit pixel in the group is low.
  function automatic lines_t drive_lines(input logic [FRAME_W-1:0] frame,
                                         input logic [GROUP_W-1:0] group);
    lines_t               lines;
    logic [NUM_LINES-1:0] anode;
    logic [NUM_LINES-1:0] cathode;
    lines = '0;
    anode = NUM_LINES'(1) << (LAST_GROUP - group);
    for (int row = 0; row < NUM_ROWS; row++) begin
      for (int col = 0; col < NUM_COLS; col++) begin
        cathode = NUM_LINES'(1) << (NUM_COLS - 1 - col);
        if (PIXEL_GROUP[NUM_COLS*row+col] == group && frame[NUM_COLS*row+col]) begin
          lines.enable = lines.enable | anode | cathode;
          lines.high   = lines.high | anode;
        end
      end
    end
    return lines;
  endfunction

endpackage

FILE: rtl/clps_if.sv
interface clps_in_if;
  logic                          valid;
  logic                          ready;
  logic                          op;
  logic [clps_pkg::FRAME_W-1:0]  frame_bits;

  modport source (output valid, output op, output frame_bits, input ready);
  modport sink   (input valid, input op, input frame_bits, output ready);
endinterface

interface clps_out_if;
  logic                            valid;
  logic                            ready;
  logic [clps_pkg::NUM_LINES-1:0]  line_enable;
  logic [clps_pkg::NUM_LINES-1:0]  line_high;
  logic [clps_pkg::GROUP_W-1:0]    scan_group;

  modport source (output valid, output line_enable, output line_high, output scan_group,
                  input ready);
  modport sink   (input valid, input line_enable, input line_high, input scan_group,
                  output ready);
endinterface

FILE: rtl/charlieplex_led_scanner.sv
// Charlieplexed 5x5 LED matrix scanner on six tri-state lines A..F.
//
// The request channel carries an opcode and a 25-bit frame. A load request
// stores the frame and restarts the scan at group 0 with a cleared dwell
// count; a tick request advances the dwell count and moves to the next of
// the six pixel groups once dwell_ticks ticks have gone by (zero acts as one).
// Every request yields exactly one result on the result channel: the line
// enables, the line levels and the group now shown.
// dwell_ticks is written through cfg_wr_en/cfg_wr_data and resets to 1; the user
// must write it only while the block is idle, as the block does not enforce this.
// A request accepted at a clock edge updates the state registers, and its result
// then moves into the output register, from which the receiver takes it.
// Throughput is one request per cycle while results drain: the state registers
// take the request, and the line pattern is decoded into a separate output
// register, so a new request is accepted while the previous result waits.
// When the receiver stalls, one more request can be held in the state stage;
// after that, request.ready drops until the output register drains.
// Synchronous reset clears the frame, the group and the dwell count, drops
// both stage valid bits and sets dwell_ticks back to 1.
module charlieplex_led_scanner (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [clps_pkg::DWELL_W-1:0]  cfg_wr_data,
  clps_in_if.sink                       request,
  clps_out_if.source                    result
);

  // Architectural state. It always reflects every accepted request.
  logic [clps_pkg::FRAME_W-1:0]  frame_store;
  logic [clps_pkg::GROUP_W-1:0]  group_index;
  logic [clps_pkg::DWELL_W-1:0]  dwell_count;
  logic [clps_pkg::DWELL_W-1:0]  dwell_ticks;

  // pend_valid marks a request whose state update is done but whose result
  // has not yet moved into the output register.
  logic pend_valid;
  logic out_valid;

  logic                          request_fire;
  logic                          out_load;
  logic [clps_pkg::DWELL_W-1:0]  dwell_limit;
  logic [clps_pkg::DWELL_W:0]    count_inc;
  logic                          advance;
  logic [clps_pkg::GROUP_W-1:0]  group_step;
  clps_pkg::lines_t              lines;

  // The output register takes the pending result when it is empty or being
  // drained in this cycle.
  assign out_load      = pend_valid && (!out_valid || result.ready);
  assign request.ready = !pend_valid || out_load;
  assign request_fire  = request.valid && request.ready;

  // Dwell compare for a tick. A limit of zero behaves as one.
  assign dwell_limit = (dwell_ticks == '0) ? clps_pkg::DWELL_RESET : dwell_ticks;
  assign count_inc   = {1'b0, dwell_count} + (clps_pkg::DWELL_W + 1)'(1);
  assign advance     = count_inc >= {1'b0, dwell_limit};
  assign group_step  = (group_index >= clps_pkg::LAST_GROUP) ? '0
                                                             : group_index + 3'd1;

  // Line pattern of the state that the pending request left behind. The state
  // does not change while a result is pending and not moving, so this is
  // always the pattern of the pending request.
  assign lines = clps_pkg::drive_lines(frame_store, group_index);

  always_ff @(posedge clk) begin
    if (rst) begin
      dwell_ticks <= clps_pkg::DWELL_RESET;
    end else if (cfg_wr_en) begin
      dwell_ticks <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_store <= '0;
      group_index <= '0;
      dwell_count <= '0;
    end else if (request_fire) begin
      if (clps_pkg::op_t'(request.op) == clps_pkg::OP_LOAD) begin
        frame_store <= request.frame_bits;
        group_index <= '0;
        dwell_count <= '0;
      end else if (advance) begin
        group_index <= group_step;
        dwell_count <= '0;
      end else begin
        dwell_count <= count_inc[clps_pkg::DWELL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (request_fire) begin
        pend_valid <= 1'b1;
      end else if (out_load) begin
        pend_valid <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload; no reset needed.
  always_ff @(posedge clk) begin
    if (out_load) begin
      result.line_enable <= lines.enable;
      result.line_high   <= lines.high;
      result.scan_group  <= group_index;
    end
  end

  assign result.valid = out_valid;

  // A load always restarts the scan.
  assert property (@(posedge clk) disable iff (rst)
    (request_fire && clps_pkg::op_t'(request.op) == clps_pkg::OP_LOAD)
      |=> (group_index == '0 && dwell_count == '0))
    else $error("load did not restart the scan");

  // A tick that does not advance keeps the group and counts up by one.
  assert property (@(posedge clk) disable iff (rst)
    (request_fire && clps_pkg::op_t'(request.op) == clps_pkg::OP_TICK && !advance)
      |=> (group_index == $past(group_index) && dwell_count == $past(dwell_count) + 16'd1))
    else $error("dwell count did not step on a tick");

  // Only enabled lines are driven high, and the group stays in range.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((result.line_high & ~result.line_enable) == '0
                   && result.scan_group <= clps_pkg::LAST_GROUP))
    else $error("result drives a tri-stated line or names a bad group");

  // A pending result moves into the output register whenever that register is empty.
  assert property (@(posedge clk) disable iff (rst)
    (pend_valid && !out_valid) |=> out_valid)
    else $error("pending result was not moved to the empty output register");

endmodule
